### sv/indent_bar_language_tokenizer_unit_assert.svh
// assertion macros for the tokenizer unit checker
`ifndef INDENT_BAR_LANGUAGE_TOKENIZER_UNIT_ASSERT_SVH
`define INDENT_BAR_LANGUAGE_TOKENIZER_UNIT_ASSERT_SVH
`define IBLT_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define IBLT_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

### sv/iblt_pkg.sv
// ----------------------------------------------------------------------------
// iblt_pkg
// shared types and constants of the bar-indented language tokenizer
// ----------------------------------------------------------------------------
package iblt_pkg;
  localparam int MaxKeywordLen = 11;
  localparam int OffsetBits = 32;
  localparam int NumKeywords = 11;

  localparam logic [4:0] K_EOF = 5'd0;
  localparam logic [4:0] K_NEWLINE = 5'd1;
  localparam logic [4:0] K_END_BLOCK = 5'd2;
  localparam logic [4:0] K_COLON = 5'd3;
  localparam logic [4:0] K_LBRACK = 5'd4;
  localparam logic [4:0] K_RBRACK = 5'd5;
  localparam logic [4:0] K_PIPE = 5'd6;
  localparam logic [4:0] K_DOT = 5'd7;
  localparam logic [4:0] K_AT = 5'd8;
  localparam logic [4:0] K_QMARK = 5'd9;
  localparam logic [4:0] K_ELLIPSIS = 5'd10;
  localparam logic [4:0] K_OPERATOR = 5'd11;
  localparam logic [4:0] K_IDENT = 5'd12;
  localparam logic [4:0] K_INT = 5'd13;
  localparam logic [4:0] K_FLOAT = 5'd14;
  localparam logic [4:0] K_STRING = 5'd15;
  localparam logic [4:0] K_CHAR = 5'd16;
  localparam logic [4:0] K_KEYWORD0 = 5'd17;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_TAB = 2'd1;
  localparam logic [1:0] E_UNKNOWN = 2'd2;
  localparam logic [1:0] E_UNTERM = 2'd3;

  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  err;
    logic [15:0] line;
    logic [15:0] col;
    logic signed [8:0] indent;
    logic [OffsetBits-1:0] start;
    logic [15:0] len;
    logic        last;
  } tok_t;

  typedef logic [MaxKeywordLen*8-1:0] word_t;

  // keyword text, first char in low byte, zero padded
  function automatic word_t kw_text(input logic [3:0] i);
    word_t w;
    w = '0;
    case (i)
      4'd0: w[31:0] = {"E", "P", "Y", "T"};
      4'd1: w[71:0] = {"E", "R", "U", "T", "C", "U", "R", "T", "S"};
      4'd2: w[39:0] = {"N", "O", "I", "N", "U"};
      4'd3: w[87:0] = {"N", "O", "I", "T", "A", "R", "E", "M", "U", "N", "E"};
      4'd4: w[15:0] = {"F", "I"};
      4'd5: w[31:0] = {"F", "I", "L", "E"};
      4'd6: w[31:0] = {"E", "S", "L", "E"};
      4'd7: w[31:0] = {"P", "O", "O", "L"};
      4'd8: w[39:0] = {"K", "A", "E", "R", "B"};
      4'd9: w[23:0] = {"T", "E", "R"};
      4'd10: w[31:0] = {"E", "Z", "I", "S"};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] i);
    logic [3:0] n;
    case (i)
      4'd0: n = 4'd4;
      4'd1: n = 4'd9;
      4'd2: n = 4'd5;
      4'd3: n = 4'd11;
      4'd4: n = 4'd2;
      4'd5, 4'd6, 4'd7, 4'd10: n = 4'd4;
      4'd8: n = 4'd5;
      4'd9: n = 4'd3;
      default: n = 4'd15;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction
endpackage

### sv/iblt_scan.sv
// ----------------------------------------------------------------------------
// iblt_scan
// front part: per-byte scanner producing up to three tokens per byte
// ----------------------------------------------------------------------------
module iblt_scan (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [7:0] char_byte,
  output logic [1:0] n_tok,
  output iblt_pkg::tok_t tok0,
  output iblt_pkg::tok_t tok1,
  output iblt_pkg::tok_t tok2,
  output logic [3:0] kw_len_q,
  output iblt_pkg::word_t kw_word_q
);
  import iblt_pkg::*;

  typedef enum logic [3:0] {
    M_TOP, M_CR, M_NL_LEAD, M_NL_BARS, M_NL_GAP, M_NL_BSL, M_SKIP, M_DOTS,
    M_NUM, M_IDENT, M_OP, M_STR
  } mode_t;

  mode_t mode, mode_next;
  logic [OffsetBits-1:0] offset, offset_next, tstart, tstart_next;
  logic [15:0] line, line_next, col, col_next, tline, tline_next, tcol, tcol_next;
  logic [15:0] tlen, tlen_next;
  logic [7:0] bars, bars_next;
  logic [1:0] dots, dots_next;
  logic saw_dot, saw_dot_next, single, single_next, esc, esc_next;
  logic halted, halted_next;
  logic [3:0] wlen, wlen_next;
  logic [7:0] wbuf [MaxKeywordLen];
  logic wr_en;
  logic [3:0] wr_idx;
  tok_t t [3];
  logic [1:0] cnt;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  always_comb begin
    mode_t m;
    logic again, line_done, stop;
    tok_t z;
    mode_next = mode; offset_next = offset; line_next = line; col_next = col;
    tstart_next = tstart; tline_next = tline; tcol_next = tcol; tlen_next = tlen;
    bars_next = bars; dots_next = dots; saw_dot_next = saw_dot;
    single_next = single; esc_next = esc; halted_next = halted; wlen_next = wlen;
    wr_en = 1'b0; wr_idx = '0;
    z = '0; z.indent = -9'sd1;
    t[0] = z; t[1] = z; t[2] = z; cnt = '0;
    line_done = 1'b0; stop = 1'b0; again = 1'b0;
    m = mode;
    if (in_valid && !halted) begin
      if (m == M_CR) begin
        line_next = sat_inc(line); col_next = 16'd1; m = M_NL_LEAD; bars_next = '0;
        if (char_byte == 8'h0A) begin
          offset_next = offset + 1'b1; stop = 1'b1;
        end
      end
      again = !stop;
      for (int pass = 0; pass < 3; pass++) begin
        if (again && !halted_next) begin
          again = 1'b0;
          unique case (m)
            M_NL_LEAD, M_NL_BARS, M_NL_GAP: begin
              if (char_byte == " ") begin
                if (m == M_NL_BARS) m = M_NL_GAP;
              end else if (char_byte == "|" && m != M_NL_GAP) begin
                if (bars_next != 8'hFF) bars_next = bars_next + 1'b1;
                m = M_NL_BARS;
              end else if (char_byte == "\\") begin
                tstart_next = offset; tline_next = line_next; tcol_next = col_next;
                tlen_next = 16'd1; m = M_NL_BSL;
              end else begin
                t[cnt] = z; t[cnt].kind = K_NEWLINE; t[cnt].line = line_next;
                t[cnt].col = 16'd1; t[cnt].indent = {1'b0, bars_next};
                cnt = cnt + 1'b1; m = M_TOP; again = 1'b1;
              end
            end
            M_NL_BSL: begin
              t[cnt] = z; t[cnt].line = line_next; t[cnt].col = 16'd1;
              t[cnt].indent = {1'b0, bars_next};
              if (char_byte == "_") begin
                t[cnt].kind = K_END_BLOCK; m = M_SKIP;
              end else begin
                t[cnt].kind = K_NEWLINE; cnt = cnt + 1'b1;
                t[cnt] = z; t[cnt].err = E_UNKNOWN; t[cnt].line = tline_next;
                t[cnt].col = tcol_next; halted_next = 1'b1; m = M_TOP;
              end
              cnt = cnt + 1'b1;
            end
            M_SKIP: begin
              if (char_byte == 8'h00 || char_byte == 8'h0D || char_byte == 8'h0A) begin
                m = M_TOP; again = 1'b1;
              end
            end
            M_DOTS: begin
              if (char_byte == ".") begin
                if (dots_next < 2'd2) dots_next = dots_next + 1'b1;
                else begin
                  t[cnt] = z; t[cnt].kind = K_ELLIPSIS; t[cnt].line = tline_next;
                  t[cnt].col = tcol_next; cnt = cnt + 1'b1;
                  dots_next = '0; m = M_TOP;
                end
              end else begin
                t[cnt] = z; t[cnt].kind = K_DOT; t[cnt].line = tline_next;
                t[cnt].col = tcol_next; cnt = cnt + 1'b1;
                if (dots_next == 2'd2) begin
                  t[cnt] = z; t[cnt].kind = K_DOT; t[cnt].line = tline_next;
                  t[cnt].col = sat_inc(tcol_next); cnt = cnt + 1'b1;
                end
                dots_next = '0; m = M_TOP; again = 1'b1;
              end
            end
            M_NUM: begin
              if (is_word(char_byte) || char_byte == ".") begin
                if (char_byte == ".") saw_dot_next = 1'b1;
                tlen_next = sat_inc(tlen_next);
              end else begin
                t[cnt] = z; t[cnt].kind = saw_dot_next ? K_FLOAT : K_INT;
                t[cnt].line = tline_next; t[cnt].col = tcol_next;
                t[cnt].start = tstart_next; t[cnt].len = tlen_next;
                cnt = cnt + 1'b1; m = M_TOP; again = 1'b1;
              end
            end
            M_IDENT: begin
              if (is_word(char_byte)) begin
                if (wlen_next < 4'(MaxKeywordLen)) begin
                  wr_en = 1'b1; wr_idx = wlen_next;
                end
                if (wlen_next <= 4'(MaxKeywordLen)) wlen_next = wlen_next + 1'b1;
                tlen_next = sat_inc(tlen_next);
              end else begin
                // keyword resolved in back part
                t[cnt] = z; t[cnt].kind = K_IDENT; t[cnt].line = tline_next;
                t[cnt].col = tcol_next; t[cnt].start = tstart_next;
                t[cnt].len = tlen_next; cnt = cnt + 1'b1; m = M_TOP; again = 1'b1;
              end
            end
            M_OP: begin
              m = M_TOP;
              t[cnt] = z; t[cnt].kind = K_OPERATOR; t[cnt].line = tline_next;
              t[cnt].col = tcol_next; t[cnt].start = tstart_next;
              if (char_byte == "=" || char_byte == "<" || char_byte == ">") begin
                t[cnt].len = sat_inc(tlen_next); tlen_next = sat_inc(tlen_next);
              end else begin
                t[cnt].len = tlen_next; again = 1'b1;
              end
              cnt = cnt + 1'b1;
            end
            M_STR: begin
              if (char_byte == 8'h00) begin
                t[cnt] = z; t[cnt].err = E_UNTERM; t[cnt].line = tline_next;
                t[cnt].col = tcol_next; cnt = cnt + 1'b1;
                halted_next = 1'b1; m = M_TOP;
              end else if (esc_next) begin
                esc_next = 1'b0; tlen_next = sat_inc(tlen_next);
              end else if (char_byte == "\\") begin
                esc_next = 1'b1; tlen_next = sat_inc(tlen_next);
              end else if (char_byte == (single_next ? 8'h27 : 8'h22)) begin
                tlen_next = sat_inc(tlen_next);
                t[cnt] = z; t[cnt].kind = single_next ? K_CHAR : K_STRING;
                t[cnt].line = tline_next; t[cnt].col = tcol_next;
                t[cnt].start = tstart_next; t[cnt].len = tlen_next;
                cnt = cnt + 1'b1; m = M_TOP;
              end else begin
                tlen_next = sat_inc(tlen_next);
              end
            end
            default: begin
              m = M_TOP;
              t[cnt] = z; t[cnt].line = line_next; t[cnt].col = col_next;
              if (char_byte == 8'h00) begin
                t[cnt].kind = K_EOF; cnt = cnt + 1'b1; halted_next = 1'b1;
              end else if (char_byte == 8'h0A) begin
                m = M_NL_LEAD; bars_next = '0; line_done = 1'b1;
              end else if (char_byte == 8'h0D) begin
                m = M_CR;
              end else if (char_byte == " ") begin
                m = M_TOP;
              end else if (char_byte == 8'h09) begin
                t[cnt].err = E_TAB; cnt = cnt + 1'b1; halted_next = 1'b1;
              end else if (char_byte == ";") begin
                m = M_SKIP;
              end else if (char_byte == ":" || char_byte == "[" || char_byte == "]" ||
                           char_byte == "|" || char_byte == "@" || char_byte == "?") begin
                t[cnt].kind = char_byte == ":" ? K_COLON : char_byte == "[" ? K_LBRACK :
                              char_byte == "]" ? K_RBRACK : char_byte == "|" ? K_PIPE :
                              char_byte == "@" ? K_AT : K_QMARK;
                cnt = cnt + 1'b1;
              end else if (char_byte == "." || char_byte == 8'h22 || char_byte == 8'h27 ||
                           is_word(char_byte) || char_byte == "+" || char_byte == "-" ||
                           char_byte == "*" || char_byte == "/" || char_byte == "%" ||
                           char_byte == "<" || char_byte == ">" || char_byte == "=" ||
                           char_byte == "!") begin
                tstart_next = offset; tline_next = line_next; tcol_next = col_next;
                tlen_next = 16'd1;
                if (char_byte == ".") begin
                  dots_next = 2'd1; m = M_DOTS;
                end else if (char_byte == 8'h22 || char_byte == 8'h27) begin
                  single_next = char_byte == 8'h27; esc_next = 1'b0; m = M_STR;
                end else if (is_digit(char_byte)) begin
                  saw_dot_next = 1'b0; m = M_NUM;
                end else if (is_word(char_byte)) begin
                  wr_en = 1'b1; wr_idx = '0; wlen_next = 4'd1; m = M_IDENT;
                end else begin
                  m = M_OP;
                end
              end else begin
                t[cnt].err = E_UNKNOWN; cnt = cnt + 1'b1; halted_next = 1'b1;
              end
            end
          endcase
        end
      end
      if (!stop && !halted_next) begin
        offset_next = offset + 1'b1;
        col_next = sat_inc(col_next);
        if (line_done) begin
          line_next = sat_inc(line_next); col_next = 16'd1;
        end
      end
      if (halted_next) m = M_TOP;
      if (cnt != 2'd0) t[cnt - 2'd1].last = 1'b1;
    end
    mode_next = m;
  end

  // identifier word for keyword check
  always_comb begin
    kw_word_q = '0;
    for (int i = 0; i < MaxKeywordLen; i++) begin
      if (4'(i) < wlen) kw_word_q[i*8 +: 8] = wbuf[i];
    end
    kw_len_q = wlen;
  end

  assign n_tok = cnt;
  assign tok0 = t[0];
  assign tok1 = t[1];
  assign tok2 = t[2];

  always_ff @(posedge clk) begin
    if (wr_en) wbuf[wr_idx] <= char_byte;
    if (rst) begin
      mode <= M_TOP; offset <= '0; line <= 16'd1; col <= 16'd1;
      tstart <= '0; tline <= 16'd1; tcol <= 16'd1; tlen <= '0;
      bars <= '0; dots <= '0; saw_dot <= 1'b0; single <= 1'b0; esc <= 1'b0;
      halted <= 1'b0; wlen <= '0;
    end else begin
      mode <= mode_next; offset <= offset_next; line <= line_next; col <= col_next;
      tstart <= tstart_next; tline <= tline_next; tcol <= tcol_next; tlen <= tlen_next;
      bars <= bars_next; dots <= dots_next; saw_dot <= saw_dot_next;
      single <= single_next; esc <= esc_next; halted <= halted_next; wlen <= wlen_next;
    end
  end
endmodule

### sv/iblt_queue.sv
// ----------------------------------------------------------------------------
// iblt_queue
// token queue between scanner and output; takes up to three tokens a cycle
// ----------------------------------------------------------------------------
module iblt_queue (
  input  logic clk,
  input  logic rst,
  input  logic [1:0] n_in,
  input  iblt_pkg::tok_t in0,
  input  iblt_pkg::tok_t in1,
  input  iblt_pkg::tok_t in2,
  input  logic pop,
  output logic empty,
  output logic room,
  output iblt_pkg::tok_t head
);
  import iblt_pkg::*;
  localparam int Depth = 8;
  tok_t mem [Depth];
  logic [2:0] rd, wr;
  logic [3:0] count, count_next;
  logic do_pop;

  assign empty = count == 4'd0;
  assign do_pop = pop && !empty;
  assign room = count <= 4'(Depth - 3) || (count == 4'(Depth - 2) && do_pop);
  assign head = mem[rd];
  assign count_next = count + 4'(n_in) - 4'(do_pop);

  always_ff @(posedge clk) begin
    if (n_in > 2'd0) mem[wr] <= in0;
    if (n_in > 2'd1) mem[wr + 3'd1] <= in1;
    if (n_in > 2'd2) mem[wr + 3'd2] <= in2;
    if (rst) begin
      rd <= '0; wr <= '0; count <= '0;
    end else begin
      wr <= wr + 3'(n_in);
      rd <= rd + 3'(do_pop);
      count <= count_next;
    end
  end
endmodule

### sv/iblt_resolve.sv
// ----------------------------------------------------------------------------
// iblt_resolve
// back part: keyword compare on identifier tokens before the queue
// ----------------------------------------------------------------------------
module iblt_resolve (
  input  iblt_pkg::tok_t tok_in,
  input  logic [3:0] wlen,
  input  iblt_pkg::word_t word,
  output iblt_pkg::tok_t tok_out
);
  import iblt_pkg::*;
  always_comb begin
    tok_out = tok_in;
    if (tok_in.kind == K_IDENT && wlen <= 4'(MaxKeywordLen)) begin
      for (int i = 0; i < NumKeywords; i++) begin
        if (kw_len(4'(i)) == wlen && kw_text(4'(i)) == word) begin
          tok_out.kind = K_KEYWORD0 + 5'(i);
          tok_out.start = '0;
          tok_out.len = '0;
        end
      end
    end
  end
endmodule

### sv/indent_bar_language_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// indent_bar_language_tokenizer_unit
// streaming tokenizer for a bar-indented language
// ----------------------------------------------------------------------------
// One source byte is taken per cycle; the scanner turns each byte into zero
// to three tokens within that cycle and writes them into an eight-entry
// token queue, keyword compare on the way in. Input is held off (full) only
// when the queue lacks room for three more tokens, so throughput is one byte
// per cycle while the consumer pops at least as fast as tokens appear.
module indent_bar_language_tokenizer_unit (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [7:0] char_byte,
  output logic empty,
  input  logic pop,
  output logic [4:0] token_kind,
  output logic [1:0] error_code,
  output logic [15:0] line_number,
  output logic [15:0] column_number,
  output logic signed [8:0] indent_level,
  output logic [31:0] lexeme_start,
  output logic [15:0] lexeme_length,
  output logic last_of_run
);
  import iblt_pkg::*;
  tok_t t0, t1, t2, r0, r1, r2, head;
  logic [1:0] n;
  logic [3:0] wl;
  word_t w;
  logic room;

  assign full = !room;

  iblt_scan u_scan (.clk, .rst, .in_valid(push && room), .char_byte, .n_tok(n),
    .tok0(t0), .tok1(t1), .tok2(t2), .kw_len_q(wl), .kw_word_q(w));
  iblt_resolve u_r0 (.tok_in(t0), .wlen(wl), .word(w), .tok_out(r0));
  iblt_resolve u_r1 (.tok_in(t1), .wlen(wl), .word(w), .tok_out(r1));
  iblt_resolve u_r2 (.tok_in(t2), .wlen(wl), .word(w), .tok_out(r2));
  iblt_queue u_q (.clk, .rst, .n_in(n), .in0(r0), .in1(r1), .in2(r2), .pop,
    .empty, .room, .head);

  assign token_kind = head.kind;
  assign error_code = head.err;
  assign line_number = head.line;
  assign column_number = head.col;
  assign indent_level = head.indent;
  assign lexeme_start = head.start;
  assign lexeme_length = head.len;
  assign last_of_run = head.last;
endmodule

### sv/iblt_checker.sv
// ----------------------------------------------------------------------------
// iblt_checker
// port-level checks of the tokenizer unit
// ----------------------------------------------------------------------------
`include "indent_bar_language_tokenizer_unit_assert.svh"
module iblt_checker (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input logic [4:0] token_kind,
  input logic [1:0] error_code,
  input logic [15:0] line_number,
  input logic signed [8:0] indent_level,
  input logic [15:0] lexeme_length
);
  import iblt_pkg::*;
  `IBLT_ASSERT_NXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(token_kind))
  `IBLT_ASSERT_IMP(a_err_kind, clk, rst, !empty && error_code != E_NONE, token_kind == K_EOF)
  `IBLT_ASSERT_IMP(a_line, clk, rst, !empty, line_number != 16'd0)
  `IBLT_ASSERT_IMP(a_indent, clk, rst, !empty && token_kind > K_END_BLOCK, indent_level == -9'sd1)
  `IBLT_ASSERT_IMP(a_no_text, clk, rst, !empty && token_kind < K_OPERATOR, lexeme_length == 16'd0)
endmodule

bind indent_bar_language_tokenizer_unit iblt_checker u_chk (.clk, .rst, .empty, .pop,
  .token_kind, .error_code, .line_number, .indent_level, .lexeme_length);

### tb/sv/indent_bar_language_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indent_bar_language_tokenizer_unit_tb
// byte stream tokenizer check against a cycle-free token predictor
// ----------------------------------------------------------------------------
// A short hand-written source exercises keywords, operators, numbers,
// literals with escapes, dot runs, bar indents and block ends; random source
// text built from well-formed tokens follows, closed by end of input or by
// one of the error cases. Tokens are predicted per accepted byte and
// compared field by field with what the block pops out.
module indent_bar_language_tokenizer_unit_tb;
  import iblt_pkg::*;

  typedef enum logic [3:0] {
    M_TOP, M_CR, M_LEAD, M_BARS, M_GAP, M_BSL, M_SKIP, M_DOTS, M_NUM, M_IDENT,
    M_OP, M_STR
  } scan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] char_byte = 8'd0;
  logic empty;
  logic pop = 1'b0;
  logic [4:0] token_kind;
  logic [1:0] error_code;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic signed [8:0] indent_level;
  logic [31:0] lexeme_start;
  logic [15:0] lexeme_length;
  logic last_of_run;

  indent_bar_language_tokenizer_unit u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .char_byte(char_byte),
    .empty(empty), .pop(pop), .token_kind(token_kind), .error_code(error_code),
    .line_number(line_number), .column_number(column_number),
    .indent_level(indent_level), .lexeme_start(lexeme_start),
    .lexeme_length(lexeme_length), .last_of_run(last_of_run)
  );

  always #10 clk = ~clk;

  string keywords [NumKeywords] = '{"TYPE", "STRUCTURE", "UNION", "ENUMERATION",
    "IF", "ELIF", "ELSE", "LOOP", "BREAK", "RET", "SIZE"};

  logic [7:0] source_q[$];
  tok_t token_q[$];
  tok_t byte_toks[$];
  int bytes_sent = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  bit drained = 1'b0;

  // tokenizer state
  scan_t mode;
  logic [31:0] offset, tok_off;
  logic [15:0] cur_line, cur_col, tok_line, tok_col, text_len;
  logic [7:0] word_buf [MaxKeywordLen];
  int word_len, bars, dots;
  bit saw_dot, single_quote, escaped, halted;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void emit(input logic [4:0] k, input logic [1:0] e,
                               input logic [15:0] ln, input logic [15:0] cl,
                               input int ind, input logic [31:0] st,
                               input logic [15:0] ln_len);
    tok_t t;
    t.kind = k;
    t.err = e;
    t.line = ln;
    t.col = cl;
    t.indent = (ind < 0) ? -9'sd1 : 9'(ind);
    t.start = st;
    t.len = ln_len;
    t.last = 1'b0;
    byte_toks.push_back(t);
  endfunction

  function automatic void fail_at(input logic [1:0] e, input logic [15:0] ln,
                                  input logic [15:0] cl);
    emit(K_EOF, e, ln, cl, -1, 0, 0);
    halted = 1'b1;
    mode = M_TOP;
  endfunction

  function automatic void open_token();
    tok_off = offset;
    tok_line = cur_line;
    tok_col = cur_col;
    text_len = 16'd1;
  endfunction

  function automatic void grow();
    if (text_len != 16'hFFFF) text_len++;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic [4:0] word_kind();
    string s;
    s = "";
    if (word_len > MaxKeywordLen) return K_IDENT;
    for (int i = 0; i < word_len; i++) s = {s, string'(word_buf[i])};
    for (int i = 0; i < NumKeywords; i++)
      if (s == keywords[i]) return K_KEYWORD0 + 5'(i);
    return K_IDENT;
  endfunction

  function automatic void reset_scanner();
    mode = M_TOP;
    offset = 0;
    cur_line = 1;
    cur_col = 1;
    tok_off = 0;
    tok_line = 1;
    tok_col = 1;
    word_len = 0;
    bars = 0;
    dots = 0;
    saw_dot = 0;
    single_quote = 0;
    escaped = 0;
    halted = 0;
    text_len = 0;
  endfunction

  // tokens caused by one accepted source byte
  function automatic void scan_byte(input logic [7:0] c);
    bit again, line_done;
    logic [4:0] k;
    line_done = 0;
    byte_toks.delete();
    if (halted) return;
    if (mode == M_CR) begin
      cur_line = sat16(cur_line);
      cur_col = 1;
      mode = M_LEAD;
      bars = 0;
      if (c == 8'h0a) begin
        offset++;
        return;
      end
    end
    do begin
      again = 0;
      case (mode)
        M_LEAD, M_BARS, M_GAP: begin
          if (c == " ") begin
            if (mode == M_BARS) mode = M_GAP;
          end else if (c == "|" && mode != M_GAP) begin
            if (bars < 255) bars++;
            mode = M_BARS;
          end else if (c == "\\") begin
            open_token();
            mode = M_BSL;
          end else begin
            emit(K_NEWLINE, E_NONE, cur_line, 1, bars, 0, 0);
            mode = M_TOP;
            again = 1;
          end
        end
        M_BSL: begin
          if (c == "_") begin
            emit(K_END_BLOCK, E_NONE, cur_line, 1, bars, 0, 0);
            mode = M_SKIP;
          end else begin
            emit(K_NEWLINE, E_NONE, cur_line, 1, bars, 0, 0);
            fail_at(E_UNKNOWN, tok_line, tok_col);
          end
        end
        M_SKIP: begin
          if (c == 0 || c == 8'h0d || c == 8'h0a) begin
            mode = M_TOP;
            again = 1;
          end
        end
        M_DOTS: begin
          if (c == ".") begin
            if (dots < 2) dots++;
            else begin
              emit(K_ELLIPSIS, E_NONE, tok_line, tok_col, -1, 0, 0);
              dots = 0;
              mode = M_TOP;
            end
          end else begin
            emit(K_DOT, E_NONE, tok_line, tok_col, -1, 0, 0);
            if (dots == 2) emit(K_DOT, E_NONE, tok_line, sat16(tok_col), -1, 0, 0);
            dots = 0;
            mode = M_TOP;
            again = 1;
          end
        end
        M_NUM: begin
          if (is_word(c) || c == ".") begin
            if (c == ".") saw_dot = 1;
            grow();
          end else begin
            emit(saw_dot ? K_FLOAT : K_INT, E_NONE, tok_line, tok_col, -1, tok_off,
                 text_len);
            mode = M_TOP;
            again = 1;
          end
        end
        M_IDENT: begin
          if (is_word(c)) begin
            if (word_len < MaxKeywordLen) word_buf[word_len] = c;
            if (word_len <= MaxKeywordLen) word_len++;
            grow();
          end else begin
            k = word_kind();
            if (k == K_IDENT) emit(K_IDENT, E_NONE, tok_line, tok_col, -1, tok_off, text_len);
            else emit(k, E_NONE, tok_line, tok_col, -1, 0, 0);
            mode = M_TOP;
            again = 1;
          end
        end
        M_OP: begin
          mode = M_TOP;
          if (c == "=" || c == "<" || c == ">") begin
            grow();
            emit(K_OPERATOR, E_NONE, tok_line, tok_col, -1, tok_off, text_len);
          end else begin
            emit(K_OPERATOR, E_NONE, tok_line, tok_col, -1, tok_off, text_len);
            again = 1;
          end
        end
        M_STR: begin
          if (c == 0) fail_at(E_UNTERM, tok_line, tok_col);
          else if (escaped) begin
            escaped = 0;
            grow();
          end else if (c == "\\") begin
            escaped = 1;
            grow();
          end else if (c == (single_quote ? 8'h27 : 8'h22)) begin
            grow();
            emit(single_quote ? K_CHAR : K_STRING, E_NONE, tok_line, tok_col, -1,
                 tok_off, text_len);
            mode = M_TOP;
          end else grow();
        end
        default: begin
          mode = M_TOP;
          if (c == 0) begin
            emit(K_EOF, E_NONE, cur_line, cur_col, -1, 0, 0);
            halted = 1;
          end else if (c == 8'h0a) begin
            mode = M_LEAD;
            bars = 0;
            line_done = 1;
          end else if (c == 8'h0d) mode = M_CR;
          else if (c == " ") begin
          end else if (c == 8'h09) fail_at(E_TAB, cur_line, cur_col);
          else if (c == ";") mode = M_SKIP;
          else if (c == ":") emit(K_COLON, E_NONE, cur_line, cur_col, -1, 0, 0);
          else if (c == "[") emit(K_LBRACK, E_NONE, cur_line, cur_col, -1, 0, 0);
          else if (c == "]") emit(K_RBRACK, E_NONE, cur_line, cur_col, -1, 0, 0);
          else if (c == "|") emit(K_PIPE, E_NONE, cur_line, cur_col, -1, 0, 0);
          else if (c == "@") emit(K_AT, E_NONE, cur_line, cur_col, -1, 0, 0);
          else if (c == "?") emit(K_QMARK, E_NONE, cur_line, cur_col, -1, 0, 0);
          else if (c == ".") begin
            open_token();
            dots = 1;
            mode = M_DOTS;
          end else if (c == 8'h22 || c == 8'h27) begin
            open_token();
            single_quote = (c == 8'h27);
            escaped = 0;
            mode = M_STR;
          end else if (is_digit(c)) begin
            open_token();
            saw_dot = 0;
            mode = M_NUM;
          end else if (is_alpha(c) || c == "_") begin
            open_token();
            word_buf[0] = c;
            word_len = 1;
            mode = M_IDENT;
          end else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
                       c == "<" || c == ">" || c == "=" || c == "!") begin
            open_token();
            mode = M_OP;
          end else fail_at(E_UNKNOWN, cur_line, cur_col);
        end
      endcase
    end while (again && !halted);
    if (!halted) begin
      offset++;
      cur_col = sat16(cur_col);
      if (line_done) begin
        cur_line = sat16(cur_line);
        cur_col = 1;
      end
    end
    if (byte_toks.size() > 0) byte_toks[byte_toks.size()-1].last = 1'b1;
    foreach (byte_toks[i]) token_q.push_back(byte_toks[i]);
  endfunction

  // source text generation
  function automatic void add(input string s);
    for (int i = 0; i < s.len(); i++) source_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len()-1)];
  endfunction

  function automatic void add_literal(input bit single);
    logic [7:0] q, b;
    q = single ? 8'h27 : 8'h22;
    source_q.push_back(q);
    repeat ($urandom_range(single ? 2 : 8)) begin
      if ($urandom_range(4) == 0) begin
        source_q.push_back("\\");
        source_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        do b = 8'($urandom_range(1, 255)); while (b == q || b == "\\");
        source_q.push_back(b);
      end
    end
    source_q.push_back(q);
  endfunction

  function automatic void add_junk_line();
    logic [7:0] b;
    repeat ($urandom_range(6)) begin
      do b = 8'($urandom_range(1, 255)); while (b == 8'h0a || b == 8'h0d);
      source_q.push_back(b);
    end
    source_q.push_back(8'h0a);
  endfunction

  function automatic void add_token();
    string wc, ident;
    wc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_";
    case ($urandom_range(11))
      0, 1: add(keywords[$urandom_range(NumKeywords-1)]);
      2: begin
        ident = string'(pick("ABEFILNPRSTUYZ_q"));
        repeat ($urandom_range(13)) ident = {ident, string'(pick(wc))};
        add(ident);
      end
      3: begin
        source_q.push_back(pick("0123456789"));
        repeat ($urandom_range(5)) source_q.push_back(pick("0123456789.xe_"));
      end
      4: begin
        source_q.push_back(pick("+-*/%<>=!"));
        if ($urandom_range(1)) source_q.push_back(pick("=<>"));
      end
      5: source_q.push_back(pick(":[]|@?"));
      6: repeat ($urandom_range(1, 4)) source_q.push_back(".");
      7: add_literal($urandom_range(1));
      8: begin
        source_q.push_back(";");
        add_junk_line();
      end
      9, 10: begin
        case ($urandom_range(2))
          0: add("\n");
          1: add("\r");
          default: add("\r\n");
        endcase
        repeat ($urandom_range(2)) add(" ");
        repeat ($urandom_range(3)) add("|");
        repeat ($urandom_range(1)) add(" ");
        if ($urandom_range(4) == 0) begin
          add("\\_");
          add_junk_line();
        end
      end
      default: add(" ");
    endcase
    if ($urandom_range(2) == 0) add(" ");
  endfunction

  function automatic void add_ending();
    case ($urandom_range(4))
      0: source_q.push_back(8'h00);
      1: source_q.push_back(8'h09);
      2: source_q.push_back($urandom_range(1) ? 8'($urandom_range(128, 255)) : pick("$\\,{"));
      3: begin
        source_q.push_back(pick("'\""));
        add("ab");
        source_q.push_back(8'h00);
      end
      default: add("\n \\x");
    endcase
    repeat (4) source_q.push_back(8'($urandom_range(255)));
  endfunction

  wire calm = bytes_sent >= 80 && bytes_sent < 140;

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        scan_byte(char_byte);
        bytes_sent++;
      end
      if (bytes_sent >= 180 && !drained && token_q.size() == 0) drained = 1'b1;
      if (!push || !full) begin
        if (source_q.size() > 0 && (calm || $urandom_range(99) >= 32) &&
            !(bytes_sent >= 180 && !drained)) begin
          push <= 1'b1;
          char_byte <= source_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tok_t got, want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = '{token_kind, error_code, line_number, column_number, indent_level,
                lexeme_start, lexeme_length, last_of_run};
        if (token_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token %p", got);
        end else begin
          want = token_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("token mismatch: expected %p actual %p", want, got);
          end
        end
      end
      pop <= (calm || $urandom_range(99) >= 32);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    reset_scanner();
    add("IF x=a<=3.5\r\n||\\_q\n |...'\\''@?:[]. \"s\" ");
    while (source_q.size() < 260) add_token();
    add_ending();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (source_q.size() > 0 || push) @(posedge clk);
    while (token_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
